// ===== src/mstu_pkg.sv =====
// Shared types and constants for the multi-slot reload timer unit.
`timescale 1ns / 1ps
`default_nettype none

package mstu_pkg;

    localparam int NUM_SLOTS   = 4;
    localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
    localparam int MASK_W      = (NUM_SLOTS > 4) ? NUM_SLOTS : 4;
    localparam logic [15:0] NO_DEADLINE = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // Per-slot update request, already qualified by the pipeline advance.
    typedef struct packed {
        logic        tick;
        logic [7:0]  elapsed;
        logic        load;
        logic        free;
        logic [15:0] first;
        logic [15:0] reload;
        logic [7:0]  owner;
    } t_slot_ctl;

    // Per-slot state as seen now, and as it will be after this item.
    typedef struct packed {
        logic        valid;
        logic [7:0]  owner;
        logic        n_valid;
        logic [15:0] n_count;
        logic        fired;
    } t_slot_stat;

endpackage

`default_nettype wire

// ===== src/mstu_slot.sv =====
// One countdown slot: stored count, reload interval and owner with its update rule.
`timescale 1ns / 1ps
`default_nettype none

module mstu_slot
    import mstu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_slot_ctl  i_ctl,
    output t_slot_stat      o_stat
);

    logic        r_valid;
    logic [15:0] r_count;
    logic [15:0] r_reload;
    logic [7:0]  r_owner;

    logic        n_valid;
    logic [15:0] n_count;
    logic        expire;
    logic [15:0] elapsed16;

    assign elapsed16 = {8'd0, i_ctl.elapsed};
    assign expire    = r_valid && (r_count <= elapsed16);

    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        if (i_ctl.load) begin
            n_valid = 1'b1;
            n_count = i_ctl.first;
        end else if (i_ctl.free) begin
            n_valid = 1'b0;
        end else if (i_ctl.tick && r_valid) begin
            if (expire) begin
                // reload wraps modulo 2^16; a one-shot slot drops out
                if (r_reload != 16'd0) begin
                    n_count = r_count + r_reload - elapsed16;
                end else begin
                    n_valid = 1'b0;
                end
            end else begin
                n_count = r_count - elapsed16;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= n_count;
        if (i_ctl.load) begin
            r_reload <= i_ctl.reload;
            r_owner  <= i_ctl.owner;
        end
    end

    assign o_stat.valid   = r_valid;
    assign o_stat.owner   = r_owner;
    assign o_stat.n_valid = n_valid;
    assign o_stat.n_count = n_count;
    assign o_stat.fired   = i_ctl.tick && expire;

endmodule

`default_nettype wire

// ===== src/multi_slot_reload_timer_unit.sv =====
// Top level of the multi-slot reload timer unit: input register, slot bank, result register.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// -------   ---------  -----------------  ----------------------------------------------
// command   in         i_valid / o_ready  i_cmd, i_tick_count, i_first_value,
//                                         i_reload_interval, i_handle
// result    out        o_valid / i_ready  o_status, o_slot_used, o_fired_mask,
//                                         o_next_deadline, o_active_slots
//
// Each command is captured in the input register; when it advances, the slot bank
// updates and the result register loads at the same edge, and the result can leave
// once the result side takes the transfer.
// One command is accepted every cycle while the result side keeps taking transfers.
// When the result register is held by a stall, the command in the input register waits
// and the input register still accepts until it is occupied.
// Reset (synchronous, active low) empties both registers and frees every slot.

module multi_slot_reload_timer_unit
    import mstu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_tick_count,
    input  wire logic [15:0] i_first_value,
    input  wire logic [15:0] i_reload_interval,
    input  wire logic [7:0]  i_handle,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [1:0]       o_slot_used,
    output logic [3:0]       o_fired_mask,
    output logic [15:0]      o_next_deadline,
    output logic [2:0]       o_active_slots
);

    // Input register
    logic        r_in_valid;
    t_cmd        r_in_cmd;
    logic [7:0]  r_in_tick;
    logic [15:0] r_in_first;
    logic [15:0] r_in_reload;
    logic [7:0]  r_in_handle;

    // Result register
    logic              r_out_valid;
    t_status           r_out_status;
    logic [IDX_W-1:0]  r_out_slot;
    logic [3:0]        r_out_fired;
    logic [15:0]       r_out_deadline;
    logic [CNT_W-1:0]  r_out_active;

    logic advance;

    t_slot_ctl  slot_ctl  [NUM_SLOTS];
    t_slot_stat slot_stat [NUM_SLOTS];

    // Decoded command and slot selection
    logic             is_start;
    logic             is_stop;
    logic             is_tick;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             match_found;
    logic [IDX_W-1:0] match_idx;

    t_status          n_status;
    logic [IDX_W-1:0] n_slot;
    logic [MASK_W-1:0] n_fired;
    logic [15:0]      n_deadline;
    logic [CNT_W-1:0] n_active;

    logic [IDX_W+1:0] slot_ext;
    logic [CNT_W+2:0] active_ext;

    // Move the held command into the bank when the result register is free or draining.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_cmd    <= t_cmd'(i_cmd);
            r_in_tick   <= i_tick_count;
            r_in_first  <= i_first_value;
            r_in_reload <= i_reload_interval;
            r_in_handle <= i_handle;
        end
    end

    always_comb begin
        is_start = 1'b0;
        is_stop  = 1'b0;
        is_tick  = 1'b0;
        unique case (r_in_cmd)
            CMD_START: is_start = 1'b1;
            CMD_STOP:  is_stop  = 1'b1;
            CMD_TICK:  is_tick  = 1'b1;
            CMD_NOP:   ;
            default:   ;
        endcase
    end

    // Lowest free slot for start, lowest valid owner match for stop.
    always_comb begin
        free_found  = 1'b0;
        free_idx    = '0;
        match_found = 1'b0;
        match_idx   = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!free_found && !slot_stat[i].valid) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
            if (!match_found && slot_stat[i].valid && slot_stat[i].owner == r_in_handle) begin
                match_found = 1'b1;
                match_idx   = IDX_W'(i);
            end
        end
    end

    // Per-slot requests, only while the command advances.
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_ctl[i].tick    = advance && is_tick;
            slot_ctl[i].elapsed = r_in_tick;
            slot_ctl[i].load    = advance && is_start && free_found && (free_idx == IDX_W'(i));
            slot_ctl[i].free    = advance && is_stop && match_found && (match_idx == IDX_W'(i));
            slot_ctl[i].first   = r_in_first;
            slot_ctl[i].reload  = r_in_reload;
            slot_ctl[i].owner   = r_in_handle;
        end
    end

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
        mstu_slot u_slot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (slot_ctl[g]),
            .o_stat  (slot_stat[g])
        );
    end

    // Result fields from the post-update slot state.
    always_comb begin
        n_status   = ST_OK;
        n_slot     = '0;
        n_fired    = '0;
        n_deadline = NO_DEADLINE;
        n_active   = '0;
        if (is_start) begin
            if (free_found) begin
                n_slot = free_idx;
            end else begin
                n_status = ST_NO_SPACE;
            end
        end
        if (is_stop) begin
            if (match_found) begin
                n_slot = match_idx;
            end else begin
                n_status = ST_NOT_FOUND;
            end
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            n_fired[i] = slot_stat[i].fired;
            if (slot_stat[i].n_valid && slot_stat[i].n_count < n_deadline) begin
                n_deadline = slot_stat[i].n_count;
            end
            n_active = n_active + CNT_W'(slot_stat[i].n_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_status   <= n_status;
            r_out_slot     <= n_slot;
            r_out_fired    <= n_fired[3:0];
            r_out_deadline <= n_deadline;
            r_out_active   <= n_active;
        end
    end

    // Show the low bits of index and count as the result fields carry them.
    assign slot_ext   = (IDX_W + 2)'(r_out_slot);
    assign active_ext = (CNT_W + 3)'(r_out_active);

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_slot_used     = slot_ext[1:0];
    assign o_fired_mask    = r_out_fired;
    assign o_next_deadline = r_out_deadline;
    assign o_active_slots  = active_ext[2:0];

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the multi-slot reload timer unit.
`timescale 1ns / 1ps

module tb_top;
    import mstu_pkg::*;

    // One command as driven on the input channel.
    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  tick;
        logic [15:0] first;
        logic [15:0] period;
        logic [7:0]  tag;
    } t_cmd_item;

    // One result as seen on the output channel.
    typedef struct packed {
        t_status     status;
        logic [1:0]  slot;
        logic [3:0]  fired;
        logic [15:0] deadline;
        logic [2:0]  active;
    } t_timer_result;

    // Stimulus row: the command, and a hand-written result where one is given.
    typedef struct packed {
        t_cmd_item     item;
        logic          typed;
        t_timer_result want;
    } t_row;

    localparam int DIRECTED_ROWS = 22;
    localparam int RANDOM_ITEMS  = 780;
    localparam int CALM_TAIL     = 120;   // last items run with no idling at all
    localparam int LONG_HOLD     = 48;    // receiver hold-off, in cycles
    localparam int HOLD_AT       = 250;   // random item that triggers the hold-off

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_cmd;
    logic [7:0]  i_tick_count;
    logic [15:0] i_first_value;
    logic [15:0] i_reload_interval;
    logic [7:0]  i_handle;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [1:0]  o_slot_used;
    logic [3:0]  o_fired_mask;
    logic [15:0] o_next_deadline;
    logic [2:0]  o_active_slots;

    multi_slot_reload_timer_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_tick_count     (i_tick_count),
        .i_first_value    (i_first_value),
        .i_reload_interval(i_reload_interval),
        .i_handle         (i_handle),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_slot_used      (o_slot_used),
        .o_fired_mask     (o_fired_mask),
        .o_next_deadline  (o_next_deadline),
        .o_active_slots   (o_active_slots)
    );

    // Shadow copy of the slot bank, advanced once per accepted command.
    logic        slot_live   [NUM_SLOTS];
    logic [15:0] slot_left   [NUM_SLOTS];
    logic [15:0] slot_period [NUM_SLOTS];
    logic [7:0]  slot_tag    [NUM_SLOTS];
    int          live_cnt;

    t_timer_result pending_results[$];  // results still owed by the block, oldest first
    t_row          offered_q[$];        // rows driven on the input, not yet transferred

    bit gaps_on;        // random idling allowed on both sides
    bit long_hold_req;  // sender asks the receiver for one long hold-off
    int mismatches;
    int results_seen;
    int n_start, n_stop, n_tick, n_nop;
    int n_fires, n_full, n_missing;

    // Directed table: reset state, field extremes, every command, full bank,
    // stop with no owner, duplicate owners, exact-equal expiry, reload wrap,
    // one-shot free, zero first count, and the no-operation command.
    t_row directed_plan [DIRECTED_ROWS] = '{
        '{'{CMD_NOP,   8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b1,
          '{ST_OK,        2'd0, 4'h0, NO_DEADLINE, 3'd0}},
        '{'{CMD_TICK,  8'hFF, 16'h0000, 16'h0000, 8'h00}, 1'b1,
          '{ST_OK,        2'd0, 4'h0, NO_DEADLINE, 3'd0}},
        '{'{CMD_STOP,  8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b1,
          '{ST_NOT_FOUND, 2'd0, 4'h0, NO_DEADLINE, 3'd0}},
        '{'{CMD_START, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b1,
          '{ST_OK,        2'd0, 4'h0, 16'h0000,    3'd1}},
        '{'{CMD_START, 8'h00, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1,
          '{ST_OK,        2'd1, 4'h0, 16'h0000,    3'd2}},
        '{'{CMD_START, 8'h00, 16'd100,  16'd1,    8'hAA}, 1'b1,
          '{ST_OK,        2'd2, 4'h0, 16'h0000,    3'd3}},
        '{'{CMD_START, 8'h00, 16'd300,  16'd50,   8'h55}, 1'b1,
          '{ST_OK,        2'd3, 4'h0, 16'h0000,    3'd4}},
        '{'{CMD_START, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1,
          '{ST_NO_SPACE,  2'd0, 4'h0, 16'h0000,    3'd4}},
        '{'{CMD_TICK,  8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b0, '0},
        '{'{CMD_TICK,  8'hFF, 16'h0000, 16'h0000, 8'h00}, 1'b0, '0},
        '{'{CMD_STOP,  8'h00, 16'h0000, 16'h0000, 8'hAA}, 1'b0, '0},
        '{'{CMD_STOP,  8'h00, 16'h0000, 16'h0000, 8'hAA}, 1'b0, '0},
        '{'{CMD_START, 8'h00, 16'd10,   16'd0,    8'h55}, 1'b0, '0},
        '{'{CMD_STOP,  8'h00, 16'h0000, 16'h0000, 8'h55}, 1'b0, '0},
        '{'{CMD_TICK,  8'd45, 16'h0000, 16'h0000, 8'h00}, 1'b0, '0},
        '{'{CMD_START, 8'h00, 16'h0000, 16'hFFFF, 8'h01}, 1'b0, '0},
        '{'{CMD_TICK,  8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b0, '0},
        '{'{CMD_NOP,   8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b0, '0},
        '{'{CMD_STOP,  8'h00, 16'h0000, 16'h0000, 8'hFF}, 1'b0, '0},
        '{'{CMD_STOP,  8'h00, 16'h0000, 16'h0000, 8'h01}, 1'b0, '0},
        '{'{CMD_STOP,  8'h00, 16'h0000, 16'h0000, 8'h55}, 1'b0, '0},
        '{'{CMD_TICK,  8'h01, 16'h0000, 16'h0000, 8'h00}, 1'b0, '0}
    };

    // Apply one command to the shadow bank and return the result it causes.
    function automatic t_timer_result advance_slots(t_cmd_item it);
        t_timer_result r;
        logic          done;
        r.status   = ST_OK;
        r.slot     = 2'd0;
        r.fired    = 4'h0;
        r.deadline = NO_DEADLINE;
        done       = 1'b0;
        case (it.cmd)
            CMD_START: begin
                // take the lowest free slot
                r.status = ST_NO_SPACE;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!done && !slot_live[i]) begin
                        slot_live[i]   = 1'b1;
                        slot_left[i]   = it.first;
                        slot_period[i] = it.period;
                        slot_tag[i]    = it.tag;
                        live_cnt++;
                        r.status = ST_OK;
                        r.slot   = 2'(i);
                        done     = 1'b1;
                    end
                end
            end
            CMD_STOP: begin
                // free the lowest live slot with a matching owner
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!done && slot_live[i] && slot_tag[i] == it.tag) begin
                        slot_live[i] = 1'b0;
                        live_cnt--;
                        r.status = ST_OK;
                        r.slot   = 2'(i);
                        done     = 1'b1;
                    end
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_live[i]) begin
                        if (slot_left[i] <= {8'h00, it.tick}) begin
                            if (i < 4) r.fired[i] = 1'b1;
                            if (slot_period[i] != 16'h0000) begin
                                // reload, wrapping at 16 bits
                                slot_left[i] = slot_left[i] + slot_period[i]
                                               - {8'h00, it.tick};
                            end else begin
                                slot_live[i] = 1'b0;
                                live_cnt--;
                            end
                        end else begin
                            slot_left[i] = slot_left[i] - {8'h00, it.tick};
                        end
                    end
                end
            end
            default: ;
        endcase
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_live[i] && slot_left[i] < r.deadline) r.deadline = slot_left[i];
        end
        r.active = 3'(live_cnt);
        return r;
    endfunction

    // Drive one command and hold it until the block takes the transfer.
    task automatic offer(input t_row r);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_cmd             <= r.item.cmd;
        i_tick_count      <= r.item.tick;
        i_first_value     <= r.item.first;
        i_reload_interval <= r.item.period;
        i_handle          <= r.item.tag;
        offered_q.push_back(r);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // 10 ns clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Scoreboard: check results against the oldest expectation first, then
    // predict the command transferred at this edge. All values sampled here
    // are the ones that stood before the edge.
    always @(posedge i_clk) begin
        t_cmd_item     got_item;
        t_timer_result predicted;
        t_timer_result want;
        t_row          src;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("result with no command outstanding: status %0d deadline %0d",
                           o_status, o_next_deadline);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_status != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        mismatches++;
                    end
                    if (o_slot_used != want.slot) begin
                        $error("slot_used: expected %0d, got %0d", want.slot, o_slot_used);
                        mismatches++;
                    end
                    if (o_fired_mask != want.fired) begin
                        $error("fired_mask: expected %h, got %h", want.fired, o_fired_mask);
                        mismatches++;
                    end
                    if (o_next_deadline != want.deadline) begin
                        $error("next_deadline: expected %0d, got %0d",
                               want.deadline, o_next_deadline);
                        mismatches++;
                    end
                    if (o_active_slots != want.active) begin
                        $error("active_slots: expected %0d, got %0d",
                               want.active, o_active_slots);
                        mismatches++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                got_item.cmd    = t_cmd'(i_cmd);
                got_item.tick   = i_tick_count;
                got_item.first  = i_first_value;
                got_item.period = i_reload_interval;
                got_item.tag    = i_handle;
                src       = offered_q.pop_front();
                predicted = advance_slots(got_item);
                // hand-written rows override the predictor's answer
                pending_results.push_back(src.typed ? src.want : predicted);
                case (got_item.cmd)
                    CMD_START: n_start++;
                    CMD_STOP:  n_stop++;
                    CMD_TICK:  n_tick++;
                    default:   n_nop++;
                endcase
                n_fires += $countones(predicted.fired);
                if (predicted.status == ST_NO_SPACE)  n_full++;
                if (predicted.status == ST_NOT_FOUND) n_missing++;
            end
        end
    end

    // Result side: random short stalls, plus one long hold-off on request so
    // that both pipeline registers fill and the input stalls.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_ready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog.
    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Reset, stimulus, drain and verdict.
    initial begin
        t_row r;
        int   roll;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_cmd             = CMD_NOP;
        i_tick_count      = '0;
        i_first_value     = '0;
        i_reload_interval = '0;
        i_handle          = '0;
        gaps_on           = 1'b1;
        long_hold_req     = 1'b0;
        mismatches        = 0;
        results_seen      = 0;
        n_start = 0; n_stop = 0; n_tick = 0; n_nop = 0;
        n_fires = 0; n_full = 0; n_missing = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_live[i]   = 1'b0;
            slot_left[i]   = '0;
            slot_period[i] = '0;
            slot_tag[i]    = '0;
        end
        live_cnt = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_ROWS; k++) offer(directed_plan[k]);

        // Random part: handles mostly from a small pool so stops find owners,
        // counts mostly small so ticks make slots expire and reload.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            gaps_on = (n < RANDOM_ITEMS - CALM_TAIL) && ((n % 96) < 64);
            if (n == HOLD_AT) long_hold_req = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 38)      r.item.cmd = CMD_START;
            else if (roll < 62) r.item.cmd = CMD_STOP;
            else if (roll < 92) r.item.cmd = CMD_TICK;
            else                r.item.cmd = CMD_NOP;
            roll = $urandom_range(0, 9);
            r.item.tag = (roll == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 5));
            roll = $urandom_range(0, 9);
            if (roll == 0)      r.item.first = 16'($urandom_range(0, 65535));
            else if (roll == 1) r.item.first = 16'h0000;
            else                r.item.first = 16'($urandom_range(1, 700));
            roll = $urandom_range(0, 9);
            if (roll < 3)       r.item.period = 16'h0000;
            else if (roll == 3) r.item.period = 16'($urandom_range(0, 65535));
            else                r.item.period = 16'($urandom_range(1, 400));
            roll = $urandom_range(0, 9);
            if (roll == 0)      r.item.tick = 8'hFF;
            else if (roll == 1) r.item.tick = 8'h00;
            else if (roll == 2) r.item.tick = 8'($urandom_range(0, 255));
            else                r.item.tick = 8'($urandom_range(1, 80));
            r.typed = 1'b0;
            r.want  = '0;
            offer(r);
        end
        i_valid <= 1'b0;

        // Drain, then keep the clock running so that any extra result would still show.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (pending_results.size() != 0 || offered_q.size() != 0) begin
            $error("results still owed at the end: %0d pending, %0d offered",
                   pending_results.size(), offered_q.size());
            mismatches++;
        end

        $display("covered %0d commands: %0d start, %0d stop, %0d tick, %0d no-op; %0d results",
                 n_start + n_stop + n_tick + n_nop, n_start, n_stop, n_tick, n_nop,
                 results_seen);
        $display("%0d slot expirations, %0d starts on a full bank, %0d stops with no owner",
                 n_fires, n_full, n_missing);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/mstu_pkg.sv
src/mstu_slot.sv
src/multi_slot_reload_timer_unit.sv
tb/tb_top.sv
